// ===== design/gamepad_menu_input_autorepeat_defines.svh =====
// Assertion macros used by the checker file of the pad input autorepeat block
`ifndef GAMEPAD_MENU_INPUT_AUTOREPEAT_DEFINES_SVH
`define GAMEPAD_MENU_INPUT_AUTOREPEAT_DEFINES_SVH

// Check an implication sampled on the rising clock, idle during reset
`define GMIA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Check a property in the cycle after its trigger, idle during reset
`define GMIA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/gmia_pkg.sv =====
// Types and constants of the pad input autorepeat block
package gmia_pkg;

  localparam logic [1:0] MODE_POLL  = 2'd0;
  localparam logic [1:0] MODE_OPEN  = 2'd1;
  localparam logic [1:0] MODE_CLOSE = 2'd2;

  localparam logic [1:0] REG_STICK_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_INITIAL_DELAY   = 2'd1;
  localparam logic [1:0] REG_REPEAT_PERIOD   = 2'd2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [14:0] THRESHOLD_RESET = 15'd18000;
  localparam logic [15:0] DELAY_RESET     = 16'd400;
  localparam logic [15:0] PERIOD_RESET    = 16'd130;

  localparam logic [3:0] DIR_UP    = 4'b0001;
  localparam logic [3:0] DIR_DOWN  = 4'b0010;
  localparam logic [3:0] DIR_LEFT  = 4'b0100;
  localparam logic [3:0] DIR_RIGHT = 4'b1000;

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        raw_buttons;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic [31:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    logic [15:0] game_buttons;
    logic        suppress_pad;
    logic [15:0] menu_event;
    logic        menu_event_valid;
  } out_item_t;

  typedef struct packed {
    logic [14:0] stick_threshold;
    logic [15:0] initial_delay_ms;
    logic [15:0] repeat_period_ms;
  } cfg_t;

endpackage

// ===== design/gmia_if.sv =====
// Valid/ready channel interfaces for pad items and filter results
interface gmia_in_if import gmia_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface gmia_out_if import gmia_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/gmia_cfg_regs.sv =====
// Configuration registers: stick threshold, initial delay, repeat period
module gmia_cfg_regs import gmia_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STICK_THRESHOLD: cfg_d.stick_threshold  = cfg_data_i[14:0];
        REG_INITIAL_DELAY:   cfg_d.initial_delay_ms = cfg_data_i;
        REG_REPEAT_PERIOD:   cfg_d.repeat_period_ms = cfg_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stick_threshold  <= THRESHOLD_RESET;
      cfg_q.initial_delay_ms <= DELAY_RESET;
      cfg_q.repeat_period_ms <= PERIOD_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/gmia_core.sv =====
// Filter state and one-pass logic: direction fold, press detect, autorepeat, menu gating
module gmia_core import gmia_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  logic [15:0] prior_q, prior_d;
  logic [15:0] blocked_q, blocked_d;
  logic [31:0] deadline_q, deadline_d;
  logic        shown_q, shown_d;

  logic signed [16:0] thr_pos, thr_neg, sx, sy;
  logic [3:0]         dirs;
  logic [15:0]        buttons, pressed, blocked_poll;
  logic [31:0]        since_deadline;
  logic               dir_change, repeat_due;

  assign thr_pos = $signed({2'b00, cfg_i.stick_threshold});
  assign thr_neg = -thr_pos;
  assign sx      = 17'(item_i.stick_x);
  assign sy      = 17'(item_i.stick_y);

  always_comb begin
    dirs = '0;
    if (sy > thr_pos) dirs = dirs | DIR_UP;
    if (sy < thr_neg) dirs = dirs | DIR_DOWN;
    if (sx < thr_neg) dirs = dirs | DIR_LEFT;
    if (sx > thr_pos) dirs = dirs | DIR_RIGHT;
  end

  assign buttons        = item_i.raw_buttons | {12'd0, dirs};
  assign since_deadline = item_i.time_ms - deadline_q;
  assign dir_change     = buttons[3:0] != prior_q[3:0];
  assign repeat_due     = !dir_change && (buttons[3:0] != 4'd0) && !since_deadline[31];
  assign blocked_poll   = blocked_q & buttons;

  always_comb begin
    pressed = buttons & ~prior_q;
    if (repeat_due) pressed = pressed | {12'd0, buttons[3:0]};
  end

  always_comb begin
    prior_d    = prior_q;
    blocked_d  = blocked_q;
    deadline_d = deadline_q;
    shown_d    = shown_q;
    result_o   = '0;
    case (item_i.mode)
      MODE_POLL: begin
        prior_d   = buttons;
        blocked_d = blocked_poll;
        if (dir_change) begin
          deadline_d = item_i.time_ms + {16'd0, cfg_i.initial_delay_ms};
        end else if (repeat_due) begin
          deadline_d = item_i.time_ms + {16'd0, cfg_i.repeat_period_ms};
        end
        if (!shown_q) begin
          result_o.game_buttons = item_i.raw_buttons & ~blocked_poll;
        end else begin
          result_o.suppress_pad     = 1'b1;
          result_o.menu_event       = pressed;
          result_o.menu_event_valid = pressed != 16'd0;
        end
      end
      MODE_OPEN: begin
        shown_d = 1'b1;
      end
      MODE_CLOSE: begin
        blocked_d = blocked_q | prior_q;
        shown_d   = 1'b0;
      end
      default: begin
        shown_d = shown_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q    <= '0;
      blocked_q  <= '0;
      deadline_q <= '0;
      shown_q    <= 1'b0;
    end else if (fire_i) begin
      prior_q    <= prior_d;
      blocked_q  <= blocked_d;
      deadline_q <= deadline_d;
      shown_q    <= shown_d;
    end
  end

endmodule

// ===== design/gamepad_menu_input_autorepeat.sv =====
// Top level of the pad input filter with menu gating and direction autorepeat
//
//   channel  dir  handshake          payload
//   in_i     in   valid/ready        mode, raw_buttons, stick_x, stick_y, time_ms
//   res_o    out  valid/ready        game_buttons, suppress_pad, menu_event,
//                                    menu_event_valid
//   cfg      in   cfg_we_i           cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while the result is not stalled; an item passes the input
// register, then the result register, and its result can transfer out once registered.
// The single filter pass lies between the two registers.
// Reset clears the filter state, both valid flags and loads the register defaults.
// A stalled result holds; the input register still takes an item while the result
// register drains in the same cycle.
module gamepad_menu_input_autorepeat import gmia_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  gmia_in_if.sink             in_i,
  gmia_out_if.source          res_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg;
  in_item_t  in_q;
  out_item_t out_q, result;
  logic      in_valid_q, in_valid_d;
  logic      out_valid_q, out_valid_d;
  logic      advance, fire, in_ready;

  gmia_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  gmia_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign advance     = !out_valid_q || res_o.ready;
  assign fire        = in_valid_q && advance;
  assign in_ready    = !in_valid_q || advance;
  assign in_valid_d  = in_ready ? in_i.valid : in_valid_q;
  assign out_valid_d = advance ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) in_q <= in_i.payload;
    if (fire) out_q <= result;
  end

  assign in_i.ready    = in_ready;
  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

endmodule

// ===== design/gmia_checker.sv =====
// Port-level checks of the pad input filter, bound to the top level
`include "gamepad_menu_input_autorepeat_defines.svh"

module gmia_checker import gmia_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      res_valid_i,
  input logic      res_ready_i,
  input out_item_t res_payload_i
);

  `GMIA_ASSERT_IMP(a_suppress_zero, clk_i, rst_ni, res_valid_i && res_payload_i.suppress_pad, res_payload_i.game_buttons == 16'd0, "game buttons seen while pad suppressed")
  `GMIA_ASSERT_IMP(a_event_flag, clk_i, rst_ni, res_valid_i, res_payload_i.menu_event_valid == (res_payload_i.menu_event != 16'd0), "menu event flag disagrees with mask")
  `GMIA_ASSERT_IMP(a_event_needs_menu, clk_i, rst_ni, res_valid_i && !res_payload_i.suppress_pad, res_payload_i.menu_event == 16'd0, "menu event while menu hidden")
  `GMIA_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(res_payload_i), "stalled result changed")

endmodule

bind gamepad_menu_input_autorepeat gmia_checker u_gmia_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_payload_i (res_o.payload)
);
